/* hw/rtl/track_range_partitioner_assert.svh */
// assertion macros for the track range partitioner
// no dependencies; taken in by the top level with `include

`ifndef TRACK_RANGE_PARTITIONER_ASSERT_SVH
`define TRACK_RANGE_PARTITIONER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/trp_pkg.sv */
// shared constants, types and state encoding of the track range partitioner
// no dependencies; imported by every other file of the block but trp_ram and the assertion header

package trp_pkg;

    // table and sample sizes
    localparam int MAX_POINTS  = 63;
    localparam int SAMPLE_BITS = 28;
    localparam int SPAN_W      = SAMPLE_BITS + 1;
    localparam int ADDR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int IDX_W       = 6;
    localparam int TRK_W       = 6;
    localparam int COUNT_W     = 6;
    localparam int CFG_IDX_W   = 2;

    // request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEGAL_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGAL_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_END,
        ST_PRE_RD,
        ST_PRE_CAP,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    // configuration as seen by the sequencer (point count already clamped)
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] legal_lower;
        logic [SAMPLE_BITS-1:0] legal_upper;
        logic [CNT_W-1:0]       points;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] block_offset;
        logic [SAMPLE_BITS-1:0] block_length;
    } t_query;

    // operands of the shared compare unit
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] point;
        logic [SAMPLE_BITS-1:0] prev;
        logic [SAMPLE_BITS-1:0] span_lo;
        logic [SAMPLE_BITS-1:0] span_hi;
        logic [CNT_W-1:0]       trk;
        logic [CNT_W-1:0]       trk_first;
        logic [CNT_W-1:0]       trk_last;
    } t_unit_in;

    typedef struct packed {
        logic ge_lo;
        logic ge_hi;
    } t_scan_flags;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] part_begin;
        logic [SAMPLE_BITS-1:0] part_end;
        logic                   begins_track;
        logic                   finishes_track;
        logic [TRK_W-1:0]       track_index;
        logic                   last;
    } t_part;

endpackage

/* hw/rtl/trp_req_if.sv */
// request channel of the track range partitioner (load and query items)
// depends on trp_pkg

interface trp_req_if import trp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [IDX_W-1:0]       point_index;
    logic [SAMPLE_BITS-1:0] point_value;
    logic [SAMPLE_BITS-1:0] block_offset;
    logic [SAMPLE_BITS-1:0] block_length;

    modport source (output valid, op, point_index, point_value, block_offset, block_length,
                    input ready);
    modport sink   (input valid, op, point_index, point_value, block_offset, block_length,
                    output ready);
endinterface

/* hw/rtl/trp_res_if.sv */
// result channel of the track range partitioner (one partition per item; a query can give several or none)
// depends on trp_pkg

interface trp_res_if import trp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] part_begin;
    logic [SAMPLE_BITS-1:0] part_end;
    logic                   begins_track;
    logic                   finishes_track;
    logic [TRK_W-1:0]       track_index;
    logic                   last;

    modport source (output valid, part_begin, part_end, begins_track, finishes_track,
                    track_index, last, input ready);
    modport sink   (input valid, part_begin, part_end, begins_track, finishes_track,
                    track_index, last, output ready);
endinterface

/* hw/rtl/trp_cfg_if.sv */
// configuration write channel of the track range partitioner
// depends on trp_pkg

interface trp_cfg_if import trp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [SAMPLE_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/track_range_partitioner.sv */
// top level of the track range partitioner: configuration registers, table
// ram and query sequencer; depends on trp_pkg, the channel interfaces,
// trp_ram, trp_seq and track_range_partitioner_assert.svh

// A load request writes one track start into the table and the block stays
// ready. A query request keeps the request channel not ready while it runs: it
// takes and clips the block, reads and compares each table point scanned (the
// scan stops at the first point above the clipped end), closes the scan, and
// when a scanned point lies at or below the span start fetches the start of
// the first touched track; then it reads and emits each partition, waiting
// while the result side holds off. A rejected block ends the query after
// clipping. The pace is set by the single read port of the table ram, which
// every scan step and every partition goes through with a registered read. A
// finished partition waits in an output register, so the next request is taken
// while the last partition of a query is still pending.

`include "track_range_partitioner_assert.svh"

module track_range_partitioner import trp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    trp_req_if.sink    i_req,
    trp_cfg_if.sink    i_cfg,
    trp_res_if.source  o_res
);

    logic [SAMPLE_BITS-1:0] r_legal_lower;
    logic [SAMPLE_BITS-1:0] r_legal_upper;
    logic [COUNT_W-1:0]     r_point_count;

    t_cfg                   cfg;
    t_query                 query;
    t_part                  part;
    logic                   req_acc;
    logic                   query_acc;
    logic                   load_acc;
    logic                   part_open;
    logic                   load_we;
    logic                   seq_idle;
    logic [ADDR_W-1:0]      raddr;
    logic [SAMPLE_BITS-1:0] rdata;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legal_lower <= '0;
            r_legal_upper <= '0;
            r_point_count <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LEGAL_LOWER: r_legal_lower <= i_cfg.data;
                CFG_LEGAL_UPPER: r_legal_upper <= i_cfg.data;
                CFG_POINT_COUNT: r_point_count <= i_cfg.data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamped configuration for the sequencer
    always_comb begin
        cfg.legal_lower = r_legal_lower;
        cfg.legal_upper = r_legal_upper;
        cfg.points      = (r_point_count > COUNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                                 : CNT_W'(r_point_count);
    end

    // request acceptance; loads go straight to the table
    assign i_req.ready = seq_idle;
    assign req_acc     = i_req.valid && i_req.ready;
    assign query_acc   = req_acc && (i_req.op == OP_QUERY);
    assign load_acc    = req_acc && (i_req.op == OP_LOAD);
    assign load_we     = load_acc && (i_req.point_index < IDX_W'(MAX_POINTS));

    assign query.block_offset = i_req.block_offset;
    assign query.block_length = i_req.block_length;

    trp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_req.point_index[ADDR_W-1:0]),
        .i_wdata (i_req.point_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    trp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (query_acc),
        .i_query (query),
        .i_cfg   (cfg),
        .o_idle  (seq_idle),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_part  (part)
    );

    // result channel payload
    assign o_res.part_begin     = part.part_begin;
    assign o_res.part_end       = part.part_end;
    assign o_res.begins_track   = part.begins_track;
    assign o_res.finishes_track = part.finishes_track;
    assign o_res.track_index    = part.track_index;
    assign o_res.last           = part.last;

    // a partition other than the last is waiting
    assign part_open = o_res.valid && !o_res.last;

    // a query holds the request channel off in the following cycle
    `TRP_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, query_acc, !i_req.ready, "query kept ready")
    // a load never leaves the idle state
    `TRP_ASSERT_NXT(a_load_idle, i_clk, i_rst_n, load_acc, i_req.ready, "load left block busy")
    // while a partition other than the last waits, the query is still running
    `TRP_ASSERT_IMP(a_run_open, i_clk, i_rst_n, part_open, !i_req.ready, "ready mid query")

endmodule

/* hw/rtl/trp_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module trp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/trp_unit.sv */
// shared compare unit: scan compares against one table point, and the
// bounds and flags of one partition; depends on trp_pkg

module trp_unit import trp_pkg::*; (
    input  t_unit_in                i_op,
    input  t_cfg                    i_cfg,
    output t_scan_flags             o_flags,
    output t_part                   o_part
);

    logic signed [SPAN_W-1:0] eot;
    logic signed [SPAN_W-1:0] hi_s;
    logic signed [SPAN_W-1:0] lu_s;
    logic signed [SPAN_W-1:0] up_s;
    logic                     has_end;
    logic                     first;

    // scan: does the point lie at or below the span start and end
    assign o_flags.ge_lo = (i_op.span_lo >= i_op.point);
    assign o_flags.ge_hi = (i_op.span_hi >= i_op.point);

    // end of track is one below the next point, may be minus one
    assign eot     = $signed({1'b0, i_op.point}) - $signed(SPAN_W'(1));
    assign hi_s    = $signed({1'b0, i_op.span_hi});
    assign lu_s    = $signed({1'b0, i_cfg.legal_upper});
    assign has_end = (i_op.trk < i_cfg.points);
    assign first   = (i_op.trk == i_op.trk_first);
    assign up_s    = (has_end && (eot < hi_s)) ? eot : hi_s;

    // partition fields
    always_comb begin
        o_part.part_begin     = first ? i_op.span_lo : i_op.prev;
        o_part.part_end       = up_s[SAMPLE_BITS-1:0];
        o_part.begins_track   = first ? ((i_op.span_lo == i_op.prev) ||
                                         (i_op.span_lo == i_cfg.legal_lower)) : 1'b1;
        o_part.finishes_track = (has_end && (up_s == eot)) || (up_s == lu_s);
        o_part.track_index    = TRK_W'(i_op.trk);
        o_part.last           = (i_op.trk == i_op.trk_last);
    end

endmodule

/* hw/rtl/trp_seq.sv */
// query sequencer: clipping, table scan, partition walk and output register
// depends on trp_pkg, trp_unit

module trp_seq import trp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_query            i_query,
    input  t_cfg              i_cfg,
    output logic              o_idle,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [SAMPLE_BITS-1:0] i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output t_part             o_part
);

    t_state                 r_state, n_state;
    t_query                 r_q, n_q;
    logic [SAMPLE_BITS-1:0] r_rl, n_rl;
    logic [SAMPLE_BITS-1:0] r_ru, n_ru;
    logic [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]       r_b, n_b;
    logic [CNT_W-1:0]       r_e, n_e;
    logic [CNT_W-1:0]       r_t, n_t;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_ov, n_ov;
    t_part                  r_part, n_part;

    logic [SPAN_W-1:0]      hi;
    logic                   reject;
    logic                   slot_free;
    t_unit_in               unit_in;
    t_scan_flags            flags;
    t_part                  part;

    // block end, kept one bit wider so it never wraps
    assign hi = {1'b0, r_q.block_offset} + {1'b0, r_q.block_length} - SPAN_W'(1);
    assign reject = (r_q.block_length == '0) ||
                    (i_cfg.legal_lower > i_cfg.legal_upper) ||
                    (hi < {1'b0, i_cfg.legal_lower}) ||
                    (r_q.block_offset > i_cfg.legal_upper);

    assign slot_free = !r_ov || i_ready;

    // shared compare unit
    always_comb begin
        unit_in.point     = i_rdata;
        unit_in.prev      = r_prev;
        unit_in.span_lo   = r_rl;
        unit_in.span_hi   = r_ru;
        unit_in.trk       = r_t;
        unit_in.trk_first = r_b;
        unit_in.trk_last  = r_e;
    end

    trp_unit u_unit (
        .i_op    (unit_in),
        .i_cfg   (i_cfg),
        .o_flags (flags),
        .o_part  (part)
    );

    // next state and datapath control
    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        n_rl    = r_rl;
        n_ru    = r_ru;
        n_prev  = r_prev;
        n_b     = r_b;
        n_e     = r_e;
        n_t     = r_t;
        n_idx   = r_idx;
        n_ov    = r_ov;
        n_part  = r_part;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_q     = i_query;
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: begin
                n_rl = (r_q.block_offset > i_cfg.legal_lower) ? r_q.block_offset
                                                              : i_cfg.legal_lower;
                n_ru = (hi < {1'b0, i_cfg.legal_upper}) ? hi[SAMPLE_BITS-1:0]
                                                        : i_cfg.legal_upper;
                n_b   = '0;
                n_e   = '0;
                n_t   = '0;
                n_idx = '0;
                n_prev = '0;
                if (reject) begin
                    n_state = ST_IDLE;
                end else if (i_cfg.points == '0) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (flags.ge_lo) begin
                    n_b = r_b + CNT_W'(1);
                end
                if (flags.ge_hi) begin
                    n_e = r_e + CNT_W'(1);
                end
                if (flags.ge_hi && (r_idx + CNT_W'(1) != i_cfg.points)) begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                if (r_b != '0) begin
                    n_idx   = r_b - CNT_W'(1);
                    n_state = ST_PRE_RD;
                end else begin
                    n_prev  = '0;
                    n_t     = '0;
                    n_idx   = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_PRE_RD: begin
                n_state = ST_PRE_CAP;
            end
            ST_PRE_CAP: begin
                // start of the track holding the span start
                n_prev  = i_rdata;
                n_t     = r_b;
                n_idx   = r_b;
                n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_part = part;
                    n_ov   = 1'b1;
                    n_prev = i_rdata;
                    if (r_t == r_e) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_t     = r_t + CNT_W'(1);
                        n_idx   = r_t + CNT_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_rl   <= n_rl;
        r_ru   <= n_ru;
        r_prev <= n_prev;
        r_b    <= n_b;
        r_e    <= n_e;
        r_t    <= n_t;
        r_idx  <= n_idx;
        r_part <= n_part;
    end

    assign o_idle  = (r_state == ST_IDLE);
    assign o_raddr = r_idx[ADDR_W-1:0];
    assign o_valid = r_ov;
    assign o_part  = r_part;

endmodule

/* tb/trp_partition_checker.sv */
// checker of the track range partitioner: follows loads and register writes,
// predicts the partitions of every query and compares them with the results
`timescale 1ns / 100ps

module trp_partition_checker import trp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    trp_req_if   i_req,
    trp_cfg_if   i_cfg,
    trp_res_if   i_res,
    output int   o_mismatches,
    output int   o_waiting,
    output int   o_parts_checked,
    output int   o_queries_seen
);

    // own copy of the registers and the track start table
    logic [SAMPLE_BITS-1:0] legal_lo;
    logic [SAMPLE_BITS-1:0] legal_hi;
    logic [COUNT_W-1:0]     points_set;
    logic [SAMPLE_BITS-1:0] track_start_tbl [MAX_POINTS];

    t_part parts_due [$];
    int    mismatches    = 0;
    int    parts_checked = 0;
    int    queries_seen  = 0;

    function automatic longint tbl(input int i);
        return longint'(track_start_tbl[i]);
    endfunction

    // values wrap to the sample width, as the block's registers do
    function automatic t_part make_part(input longint pb, input longint pe, input bit sb,
                                        input bit fe, input int trk, input bit lst);
        t_part p;
        p.part_begin     = SAMPLE_BITS'(pb);
        p.part_end       = SAMPLE_BITS'(pe);
        p.begins_track   = sb;
        p.finishes_track = fe;
        p.track_index    = TRK_W'(trk);
        p.last           = lst;
        return p;
    endfunction

    // clip the block to the legal range and cut it at the track starts
    task automatic split_block(input logic [SAMPLE_BITS-1:0] offset,
                               input logic [SAMPLE_BITS-1:0] length);
        longint lo, hi, ll, lu, rl, ru, up, eot, sot;
        int     n, b, e, i;
        bit     fin;
        ll = legal_lo;
        lu = legal_hi;
        lo = offset;
        hi = lo + longint'(length) - 1;
        if (length == 0 || ll > lu || hi < ll || lo > lu) return;
        rl = (lo > ll) ? lo : ll;
        ru = (hi < lu) ? hi : lu;
        n  = (points_set > MAX_POINTS) ? MAX_POINTS : int'(points_set);

        // empty table: one partition in track zero
        if (n == 0) begin
            parts_due.push_back(make_part(rl, ru, rl == ll, ru == lu, 0, 1'b1));
            return;
        end

        // start track and end track; the scan stops at the first point past the end
        b = 0;
        e = 0;
        for (i = 0; i < n; i++) begin
            if (rl >= tbl(i)) b++;
            if (ru >= tbl(i)) e++;
            else break;
        end

        // front partition
        sot = (b == 0) ? 0 : tbl(b - 1);
        up  = ru;
        if (b < n) begin
            eot = tbl(b) - 1;
            if (eot < up) up = eot;
            fin = (up == eot) || (up == lu);
        end else begin
            fin = (up == lu);
        end
        parts_due.push_back(make_part(rl, up, (rl == sot) || (rl == ll), fin, b, b == e));
        if (b == e) return;

        // whole tracks in between
        for (i = b; i + 1 < e; i++)
            parts_due.push_back(make_part(tbl(i), tbl(i + 1) - 1, 1'b1, 1'b1, i + 1, 1'b0));

        // back partition; past the last point only the legal upper bound ends it
        up = ru;
        if (e < n) begin
            eot = tbl(e) - 1;
            if (eot < up) up = eot;
            fin = (up == eot) || (up == lu);
        end else begin
            fin = (up == lu);
        end
        parts_due.push_back(make_part(tbl(e - 1), up, 1'b1, fin, e, 1'b1));
    endtask

    // watch all three channels at every edge
    always @(posedge i_clk) begin : watch
        t_part got;
        t_part want;
        bit    bad;
        if (!i_rst_n) begin
            legal_lo   = '0;
            legal_hi   = '0;
            points_set = '0;
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_LEGAL_LOWER: legal_lo = i_cfg.data;
                    CFG_LEGAL_UPPER: legal_hi = i_cfg.data;
                    CFG_POINT_COUNT: points_set = i_cfg.data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            // load and query requests
            if (i_req.valid && i_req.ready) begin
                if (i_req.op == OP_LOAD) begin
                    if (i_req.point_index < MAX_POINTS)
                        track_start_tbl[i_req.point_index] = i_req.point_value;
                end else begin
                    queries_seen++;
                    split_block(i_req.block_offset, i_req.block_length);
                end
            end

            // partitions leaving the block
            if (i_res.valid && i_res.ready) begin
                got.part_begin     = i_res.part_begin;
                got.part_end       = i_res.part_end;
                got.begins_track   = i_res.begins_track;
                got.finishes_track = i_res.finishes_track;
                got.track_index    = i_res.track_index;
                got.last           = i_res.last;
                if (parts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected partition begin %0d end %0d track %0d",
                                 $time, got.part_begin, got.part_end, got.track_index);
                end else begin
                    want = parts_due.pop_front();
                    parts_checked++;
                    bad = (got.part_begin !== want.part_begin)
                       || (got.part_end !== want.part_end)
                       || (got.begins_track !== want.begins_track)
                       || (got.finishes_track !== want.finishes_track)
                       || (got.track_index !== want.track_index)
                       || (got.last !== want.last);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: partition %0d expected begin %0d end %0d bt %0b ft %0b",
                                     $time, parts_checked, want.part_begin, want.part_end,
                                     want.begins_track, want.finishes_track);
                            $display("    track %0d last %0b, got begin %0d end %0d bt %0b ft %0b",
                                     want.track_index, want.last, got.part_begin,
                                     got.part_end, got.begins_track, got.finishes_track);
                            $display("    track %0d last %0b", got.track_index, got.last);
                        end
                    end
                end
            end
        end
        o_mismatches    <= mismatches;
        o_waiting       <= parts_due.size();
        o_parts_checked <= parts_checked;
        o_queries_seen  <= queries_seen;
    end

endmodule

/* tb/tb_top.sv */
// testbench top of the track range partitioner: clock, reset, stimulus and verdict
// depends on trp_pkg, the channel interfaces, the block and trp_partition_checker
`timescale 1ns / 100ps

module tb_top;
    import trp_pkg::*;

    localparam int     ITEMS          = 400;
    localparam int     SETTLE_CYCLES  = 300;
    localparam int     HOLD_CYCLES    = 600;
    localparam int     PRESSURE_PHASE = 1;
    localparam longint SAMPLE_MAX     = (longint'(1) << SAMPLE_BITS) - 1;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    logic hold_now;

    int mismatches;
    int waiting;
    int parts_checked;
    int queries_seen;
    int requests_sent = 0;
    int loads_sent    = 0;
    int phases        = 0;

    trp_req_if req_ch ();
    trp_cfg_if cfg_ch ();
    trp_res_if res_ch ();

    track_range_partitioner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    trp_partition_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_cfg           (cfg_ch),
        .i_res           (res_ch),
        .o_mismatches    (mismatches),
        .o_waiting       (waiting),
        .o_parts_checked (parts_checked),
        .o_queries_seen  (queries_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #3_000_000;
        $display("track_range_partitioner: mismatch");
        $finish;
    end

    // result side: random stalls, one long hold-off on request, none while calm
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_now && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= 19);
            end
        end
    end

    function automatic longint clip_sample(input longint v);
        return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
    endfunction

    // one request, held until the block takes it
    task automatic send_request(input logic op, input int idx, input longint val,
                                input longint offset, input longint length);
        while (!calm && $urandom_range(99) < 19) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.point_index  <= IDX_W'(idx);
        req_ch.point_value  <= SAMPLE_BITS'(val);
        req_ch.block_offset <= SAMPLE_BITS'(offset);
        req_ch.block_length <= SAMPLE_BITS'(length);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        requests_sent++;
        if (op == OP_LOAD) loads_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint data);
        while (!calm && $urandom_range(99) < 19) begin
            cfg_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= SAMPLE_BITS'(data);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // wait for every partition, then for a query that may still give none
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input longint lower, input longint upper, input int count);
        settle();
        write_reg(CFG_LEGAL_LOWER, lower);
        write_reg(CFG_LEGAL_UPPER, upper);
        write_reg(CFG_POINT_COUNT, count);
        cfg_ch.valid <= 1'b0;
        phases++;
    endtask

    initial begin : stimulus
        logic [SAMPLE_BITS-1:0] pts [MAX_POINTS];
        int     n, nq, sel, rot, gap, bigs, rphase, i, j, k;
        longint acc, lower, upper, off, len, margin, span, lo_anchor, hi_anchor;
        bit     ordered;

        // every input known from the start
        i_rst_n             <= 1'b0;
        calm                <= 1'b0;
        hold_now            <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_LOAD;
        req_ch.point_index  <= '0;
        req_ch.point_value  <= '0;
        req_ch.block_offset <= '0;
        req_ch.block_length <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_LEGAL_LOWER;
        cfg_ch.data         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: clipping at both bounds, blocks wholly outside
        configure(100, 1000, 0);
        send_request(OP_QUERY, 0, 0, 50, 100);
        send_request(OP_QUERY, 0, 0, 900, 500);
        send_request(OP_QUERY, 0, 0, 0, SAMPLE_MAX);
        send_request(OP_QUERY, 0, 0, 0, 50);
        send_request(OP_QUERY, 0, 0, 2000, 10);

        // three track starts and the top slot at full scale
        send_request(OP_LOAD, 0, 200, 0, 1);
        send_request(OP_LOAD, 1, 400, 0, 1);
        send_request(OP_LOAD, 2, 600, 0, 1);
        send_request(OP_LOAD, MAX_POINTS - 1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        configure(100, 1000, 3);
        send_request(OP_QUERY, 0, 0, 150, 600);
        send_request(OP_QUERY, 0, 0, 200, 200);
        send_request(OP_QUERY, 0, 0, 700, 10);
        send_request(OP_QUERY, 0, 0, SAMPLE_MAX, SAMPLE_MAX);
        send_request(OP_QUERY, 0, 0, 0, SAMPLE_MAX);

        // full legal range, single-sample blocks at both ends
        configure(0, SAMPLE_MAX, 3);
        send_request(OP_QUERY, 0, 0, SAMPLE_MAX, SAMPLE_MAX);
        send_request(OP_QUERY, 0, 0, 0, 1);

        // inverted legal range
        configure(500, 400, 3);
        send_request(OP_QUERY, 0, 0, 0, SAMPLE_MAX);

        // random phases: fresh table, new registers, then a run of queries
        rphase = 0;
        bigs   = 0;
        while (requests_sent < ITEMS) begin
            // table size, mostly small with a few full tables
            sel = $urandom_range(99);
            if (rphase == 3 || (sel < 4 && bigs < 2)) n = MAX_POINTS;
            else if (rphase == PRESSURE_PHASE) n = 8;
            else if (sel < 14) n = 0;
            else if (sel < 24) n = $urandom_range(9, MAX_POINTS - 1);
            else n = $urandom_range(1, 8);
            if (n == MAX_POINTS) bigs++;

            // ascending starts mostly, sometimes an unsorted table
            ordered = (rphase == PRESSURE_PHASE) || ($urandom_range(99) < 85);
            gap     = $urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 1 << 20);
            acc     = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, SAMPLE_MAX - 64 * gap);
            for (i = 0; i < n; i++) begin
                if (ordered) begin
                    pts[i] = SAMPLE_BITS'(acc);
                    acc += $urandom_range(1, gap);
                end else if ($urandom_range(3) == 0) begin
                    pts[i] = $urandom_range(0, 15);
                end else begin
                    pts[i] = SAMPLE_BITS'($urandom);
                end
            end

            // fill in rotated order, plus stray writes above the count
            rot = (n > 0) ? $urandom_range(0, n - 1) : 0;
            for (i = 0; i < n; i++) begin
                k = (i + rot) % n;
                send_request(OP_LOAD, k, pts[k], $urandom, $urandom);
            end
            if (n < MAX_POINTS)
                repeat ($urandom_range(0, 2))
                    send_request(OP_LOAD, $urandom_range(n, MAX_POINTS - 1), $urandom,
                                 $urandom, $urandom);

            // legal range around the table, or at the extremes
            margin    = (n > 0) ? 2 * longint'(gap) : 4096;
            lo_anchor = (n > 0) ? longint'(pts[0]) : $urandom_range(0, 1 << 20);
            hi_anchor = (n > 0) ? longint'(pts[n - 1]) : lo_anchor + $urandom_range(0, 1 << 20);
            sel = $urandom_range(99);
            if (rphase == PRESSURE_PHASE || sel < 12) begin
                lower = 0;
                upper = SAMPLE_MAX;
            end else if (sel < 18) begin
                lower = $urandom_range(1, SAMPLE_MAX);
                upper = lower - 1 - $urandom_range(0, 100);
            end else if (sel < 26) begin
                lower = lo_anchor + $urandom_range(0, gap);
                upper = lower;
            end else if (sel < 34) begin
                lower = $urandom & SAMPLE_MAX;
                upper = lower + ($urandom & SAMPLE_MAX);
            end else begin
                lower = lo_anchor - $urandom_range(0, margin);
                upper = hi_anchor + $urandom_range(0, margin);
            end
            lower = clip_sample(lower);
            upper = clip_sample(upper);
            configure(lower, upper, n);

            // one long hold-off on the result side, later a stretch without idling
            if (rphase == PRESSURE_PHASE) hold_now <= 1'b1;
            if (rphase == 5) calm <= 1'b1;
            if (rphase == 8) calm <= 1'b0;

            // queries: aligned to track starts, reaching past the end, or anywhere
            span = (upper > lower) ? upper - lower : 0;
            nq   = (rphase == PRESSURE_PHASE) ? 16 : $urandom_range(3, 10);
            for (j = 0; j < nq; j++) begin
                sel = $urandom_range(99);
                if (sel < 10) begin
                    off = $urandom & SAMPLE_MAX;
                    len = $urandom & SAMPLE_MAX;
                end else if (sel < 20) begin
                    off = lower - margin + $urandom_range(0, span + margin);
                    len = SAMPLE_MAX - $urandom_range(0, 3);
                end else if (sel < 40 && n > 0) begin
                    k   = $urandom_range(0, n - 1);
                    off = longint'(pts[k]) - $urandom_range(0, 1);
                    len = longint'(pts[$urandom_range(k, n - 1)]) - off + $urandom_range(0, 1);
                end else begin
                    off = lower - margin + $urandom_range(0, span + 2 * margin);
                    len = 1 + ($urandom_range(1) ? $urandom_range(0, 2 * gap)
                                                 : $urandom_range(0, span + margin));
                end
                off = clip_sample(off);
                len = clip_sample(len);
                if (len == 0) len = 1;
                send_request(OP_QUERY, $urandom_range(0, MAX_POINTS - 1), $urandom, off, len);
            end
            rphase++;
        end

        settle();
        $display("covered %0d requests: %0d table loads and %0d queries over %0d settings",
                 requests_sent, loads_sent, queries_seen, phases);
        $display("%0d partitions compared, %0d of them wrong or unexpected",
                 parts_checked, mismatches);
        if (mismatches == 0 && waiting == 0)
            $display("track_range_partitioner: match");
        else
            $display("track_range_partitioner: mismatch");
        $finish;
    end

endmodule
